// ===== sv/pfam_pkg.sv =====
// Package: item types, operation codes, controller states and constants for the frame allocator.
`default_nettype none
package pfam_pkg;

  localparam int PAGE_SHIFT      = 22;
  localparam int ENTRIES_PER_DIR = 1024;
  localparam int ROW_BITS        = 32;
  localparam logic [9:0] HIGH_HALF_INDEX = 10'h300;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_CHECK = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  directory;
    logic [9:0]  virtual_page;
    logic [31:0] amount;
  } in_item_t;

  typedef struct packed {
    logic       ok;
    logic [4:0] frame;
    logic [5:0] free_count;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_ALLOC,
    ST_FREE_DIR,
    ST_FREE_ROW,
    ST_SIMPLE
  } state_t;

endpackage
`default_nettype wire

// ===== sv/pfam_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module pfam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/page_frame_allocator_mapper_top.sv =====
// Top level: bitmap frame allocator with page directory memory and capacity check.
//
//  channel | ports                      | direction | payload
//  --------+----------------------------+-----------+---------------------------------
//  input   | in_valid, in_ready, in_data | in        | operation, directory, page, amount
//  result  | out_valid, out_ready, out_data | out    | ok, frame, free_count
//
// Allocate reads the frame row, then updates it; free reads the directory, then the frame
// row, then updates (no row read if the entry is absent); check reads no memory.
// One item is worked at a time; the final update waits while the output register is full.
// After reset the directory memory is swept, one entry a cycle over DIRECTORIES*1024
// entries (4096 by default), with in_ready low.
`default_nettype none
module page_frame_allocator_mapper_top #(
  parameter int FRAMES      = 32,
  parameter int DIRECTORIES = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pfam_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pfam_pkg::out_item_t     out_data
);

  import pfam_pkg::*;

  localparam int FW    = $clog2(FRAMES);
  localparam int CW    = $clog2(FRAMES + 1);
  localparam int ROWS  = (FRAMES + ROW_BITS - 1) / ROW_BITS;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int DEPTH = DIRECTORIES * ENTRIES_PER_DIR;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = FW + 1;

  // lowest row that still holds a free frame
  function automatic logic [RW-1:0] first_row(input logic [ROWS-1:0] v);
    logic [RW-1:0] r;
    r = '0;
    for (int k = ROWS - 1; k >= 0; k--) begin
      if (v[k]) r = RW'(k);
    end
    return r;
  endfunction

  // lowest clear bit of a row
  function automatic logic [4:0] first_zero(input logic [ROW_BITS-1:0] v);
    logic [4:0] r;
    r = '0;
    for (int k = ROW_BITS - 1; k >= 0; k--) begin
      if (!v[k]) r = 5'(k);
    end
    return r;
  endfunction

  // row contents before first write: frame 0 and frames past the end read as used
  function automatic logic [ROW_BITS-1:0] rst_row(input logic [RW-1:0] r);
    logic [ROW_BITS-1:0] v;
    int idx;
    v = '0;
    for (int k = 0; k < ROW_BITS; k++) begin
      idx  = int'(r) * ROW_BITS + k;
      v[k] = (idx >= FRAMES) || (idx == 0);
    end
    return v;
  endfunction

  state_t            state_r, state_nxt;
  in_item_t          item_r, item_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [4:0]        bit_r, bit_nxt;
  logic [FW-1:0]     frame_r, frame_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [ROWS-1:0]   has_free_r, has_free_nxt;
  logic [ROWS-1:0]   row_vld_r, row_vld_nxt;
  logic [AW-1:0]     init_idx_r, init_idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              dir_we, dir_re;
  logic [AW-1:0]     dir_waddr, dir_raddr;
  logic [EW-1:0]     dir_wdata, dir_q;
  logic              row_we, row_re;
  logic [RW-1:0]     row_waddr, row_raddr;
  logic [ROW_BITS-1:0] row_wdata, row_q, row_cur, row_new;

  logic              out_free;
  logic [AW-1:0]     slot_in, slot_r;
  logic              dir_ok_in;
  logic [10:0]       need;
  logic [4:0]        fb;
  logic [15:0]       f16;

  pfam_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .re    (dir_re),
    .raddr (dir_raddr),
    .rdata (dir_q)
  );

  pfam_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .re    (row_re),
    .raddr (row_raddr),
    .rdata (row_q)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  assign slot_in   = AW'({in_data.directory, in_data.virtual_page});
  assign slot_r    = AW'({item_r.directory, item_r.virtual_page});
  assign dir_ok_in = {5'd0, in_data.directory} < 7'(DIRECTORIES);
  assign row_cur   = row_vld_r[row_r] ? row_q : rst_row(row_r);
  assign fb        = first_zero(row_cur);
  assign f16       = 16'(dir_q[FW-1:0]);
  assign need      = 11'((33'(item_r.amount) + 33'((1 << PAGE_SHIFT) - 1)) >> PAGE_SHIFT);

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    row_nxt       = row_r;
    bit_nxt       = bit_r;
    frame_nxt     = frame_r;
    cnt_nxt       = cnt_r;
    has_free_nxt  = has_free_r;
    row_vld_nxt   = row_vld_r;
    init_idx_nxt  = init_idx_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;

    dir_we    = 1'b0;
    dir_waddr = slot_r;
    dir_wdata = '0;
    dir_re    = 1'b0;
    dir_raddr = slot_in;
    row_we    = 1'b0;
    row_waddr = row_r;
    row_wdata = '0;
    row_re    = 1'b0;
    row_raddr = first_row(has_free_r);
    row_new   = '0;

    case (state_r)
      ST_INIT: begin
        dir_we    = 1'b1;
        dir_waddr = init_idx_r;
        dir_wdata = {(init_idx_r[9:0] == 10'd0) || (init_idx_r[9:0] == HIGH_HALF_INDEX),
                     FW'(0)};
        init_idx_nxt = init_idx_r + AW'(1);
        if (init_idx_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          if (in_data.operation == OP_ALLOC && dir_ok_in && cnt_r != '0) begin
            row_re    = 1'b1;
            row_nxt   = first_row(has_free_r);
            state_nxt = ST_ALLOC;
          end else if (in_data.operation == OP_FREE && dir_ok_in) begin
            dir_re    = 1'b1;
            state_nxt = ST_FREE_DIR;
          end else begin
            state_nxt = ST_SIMPLE;
          end
        end
      end
      ST_ALLOC: begin
        if (out_free) begin
          row_new   = row_cur | (ROW_BITS'(1) << fb);
          row_we    = 1'b1;
          row_wdata = row_new;
          row_vld_nxt[row_r]  = 1'b1;
          has_free_nxt[row_r] = !(&row_new);
          cnt_nxt   = cnt_r - CW'(1);
          dir_we    = 1'b1;
          dir_wdata = {1'b1, FW'((16'(row_r) << 5) | 16'(fb))};
          out_valid_nxt           = 1'b1;
          out_data_nxt.ok         = 1'b1;
          out_data_nxt.frame      = 5'((16'(row_r) << 5) | 16'(fb));
          out_data_nxt.free_count = 6'(cnt_r - CW'(1));
          state_nxt = ST_IDLE;
        end
      end
      ST_FREE_DIR: begin
        if (dir_q[FW]) begin
          frame_nxt = dir_q[FW-1:0];
          row_nxt   = RW'(f16 >> 5);
          bit_nxt   = f16[4:0];
          row_re    = 1'b1;
          row_raddr = RW'(f16 >> 5);
          state_nxt = ST_FREE_ROW;
        end else if (out_free) begin
          // entry not mapped
          out_valid_nxt           = 1'b1;
          out_data_nxt.ok         = 1'b0;
          out_data_nxt.frame      = '0;
          out_data_nxt.free_count = 6'(cnt_r);
          state_nxt = ST_IDLE;
        end
      end
      ST_FREE_ROW: begin
        if (out_free) begin
          // a frame shared by more than one entry may already be free: map and count stay
          if (row_cur[bit_r]) begin
            row_new   = row_cur & ~(ROW_BITS'(1) << bit_r);
            row_we    = 1'b1;
            row_wdata = row_new;
            row_vld_nxt[row_r]  = 1'b1;
            has_free_nxt[row_r] = 1'b1;
            cnt_nxt   = cnt_r + CW'(1);
          end
          dir_we    = 1'b1;
          dir_wdata = {1'b0, frame_r};
          out_valid_nxt           = 1'b1;
          out_data_nxt.ok         = 1'b1;
          out_data_nxt.frame      = 5'(frame_r);
          out_data_nxt.free_count = row_cur[bit_r] ? 6'(cnt_r + CW'(1)) : 6'(cnt_r);
          state_nxt = ST_IDLE;
        end
      end
      ST_SIMPLE: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.ok         = (item_r.operation == OP_CHECK) && (need <= 11'(cnt_r));
          out_data_nxt.frame      = '0;
          out_data_nxt.free_count = 6'(cnt_r);
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      init_idx_r  <= '0;
      cnt_r       <= CW'(FRAMES - 1);
      has_free_r  <= '1;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_idx_r  <= init_idx_nxt;
      cnt_r       <= cnt_nxt;
      has_free_r  <= has_free_nxt;
      row_vld_r   <= row_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    row_r      <= row_nxt;
    bit_r      <= bit_nxt;
    frame_r    <= frame_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Testbench for the frame allocator and directory mapper: directed and random items.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pfam_pkg::*;

  localparam int NUM_FRAMES       = 32;
  localparam int NUM_DIRS         = 4;
  localparam int NUM_SLOTS        = NUM_DIRS * ENTRIES_PER_DIR;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS     = 1950;
  localparam int QUIET_LIMIT      = 12000;
  localparam int HOLD_CYCLES      = 250;
  localparam int OVERWRITE_BUDGET = 6;

  class frame_alloc_scoreboard;
    bit          frame_busy[NUM_FRAMES];
    int unsigned free_frames;
    bit          entry_present[NUM_SLOTS];
    logic [4:0]  entry_frame[NUM_SLOTS];
    int unsigned mapped_slots[$];
    out_item_t   expected_responses[$];
    int          mismatches;

    function new();
      for (int f = 0; f < NUM_FRAMES; f++) frame_busy[f] = (f == 0);
      free_frames = NUM_FRAMES - 1;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        entry_present[s] = 1'b0;
        entry_frame[s]   = '0;
      end
      // entries 0 and 0x300 of every directory start mapped to frame 0
      for (int d = 0; d < NUM_DIRS; d++) begin
        entry_present[d * ENTRIES_PER_DIR] = 1'b1;
        entry_present[d * ENTRIES_PER_DIR + HIGH_HALF_INDEX] = 1'b1;
        mapped_slots.push_back(d * ENTRIES_PER_DIR);
        mapped_slots.push_back(d * ENTRIES_PER_DIR + HIGH_HALF_INDEX);
      end
      mismatches = 0;
    endfunction

    task flag_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task accept_request(input in_item_t req);
      out_item_t   resp;
      int unsigned slot;
      logic [32:0] need;
      int          pick;
      int          hits[$];
      logic [4:0]  f;
      resp = '0;
      slot = int'(req.directory) * ENTRIES_PER_DIR + int'(req.virtual_page);
      case (req.operation)
        OP_CHECK: begin
          // frames needed, rounded up, formed at 33 bits so it never wraps
          need = ({1'b0, req.amount} + 33'((1 << PAGE_SHIFT) - 1)) >> PAGE_SHIFT;
          resp.ok = (need <= free_frames);
        end
        OP_ALLOC: begin
          pick = -1;
          for (int i = 0; i < NUM_FRAMES && pick < 0; i++) if (!frame_busy[i]) pick = i;
          if (pick >= 0) begin
            frame_busy[pick] = 1'b1;
            free_frames--;
            if (!entry_present[slot]) mapped_slots.push_back(slot);
            entry_present[slot] = 1'b1;
            entry_frame[slot]   = pick[4:0];
            resp.ok    = 1'b1;
            resp.frame = pick[4:0];
          end
        end
        OP_FREE: begin
          if (entry_present[slot]) begin
            f = entry_frame[slot];
            // a shared frame may already be free: leave map and count alone
            if (frame_busy[f]) begin
              frame_busy[f] = 1'b0;
              free_frames++;
            end
            entry_present[slot] = 1'b0;
            hits = mapped_slots.find_first_index(s) with (s == slot);
            if (hits.size() != 0) mapped_slots.delete(hits[0]);
            resp.ok    = 1'b1;
            resp.frame = f;
          end
        end
        default: ;
      endcase
      resp.free_count = free_frames[5:0];
      expected_responses.push_back(resp);
    endtask

    task check_response(input out_item_t got);
      out_item_t want;
      if (expected_responses.size() == 0) begin
        flag_mismatch($sformatf("result item with nothing expected: %p", got));
        return;
      end
      want = expected_responses.pop_front();
      if (got.ok !== want.ok)
        flag_mismatch($sformatf("ok got %b want %b", got.ok, want.ok));
      if (got.frame !== want.frame)
        flag_mismatch($sformatf("frame got %0d want %0d", got.frame, want.frame));
      if (got.free_count !== want.free_count)
        flag_mismatch($sformatf("free_count got %0d want %0d",
                                got.free_count, want.free_count));
    endtask
  endclass

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  frame_alloc_scoreboard sb = new();

  int send_idle_pct   = 11;
  int recv_idle_pct   = 50;
  bit hold_req        = 1'b0;
  bit hold_done       = 1'b0;
  int hold_left       = 0;
  int quiet_cycles    = 0;
  bit filling         = 1'b1;
  int overwrites_left = OVERWRITE_BUDGET;

  page_frame_allocator_mapper_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic in_item_t make_request(input logic [1:0] op, input logic [1:0] dir,
                                            input logic [9:0] page, input logic [31:0] amt);
    in_item_t req;
    req.operation    = op;
    req.directory    = dir;
    req.virtual_page = page;
    req.amount       = amt;
    return req;
  endfunction

  // Mostly well-formed traffic: fill phases push the pool to empty, drain phases
  // free mapped entries until everything is back; a little noise on top.
  function automatic in_item_t random_request();
    in_item_t    req;
    int          roll;
    int          k;
    int unsigned slot;
    req.operation    = OP_CHECK;
    req.directory    = 2'($urandom_range(0, 3));
    req.virtual_page = 10'($urandom);
    req.amount       = $urandom;
    if (filling && sb.free_frames == 0 && $urandom_range(0, 3) == 0)
      filling = 1'b0;
    else if (!filling && (sb.free_frames == NUM_FRAMES || sb.mapped_slots.size() == 0))
      filling = 1'b1;
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      req.operation = OP_UNUSED;
    end else if (roll < 16) begin
      case ($urandom_range(0, 3))
        0: req.amount = '0;
        1: req.amount = '1;
        2: begin
          // right around the current capacity
          k = int'(sb.free_frames) + int'($urandom_range(0, 2)) - 1;
          req.amount = (32'(k) << PAGE_SHIFT) + 32'($urandom_range(0, 2)) - 32'd1;
        end
        default: ;
      endcase
    end else if (roll < (filling ? 76 : 31)) begin
      req.operation = OP_ALLOC;
      if (overwrites_left > 0 && sb.mapped_slots.size() != 0 && $urandom_range(0, 49) == 0) begin
        // overwriting a mapping leaks its frame, so keep these rare
        overwrites_left--;
        slot = sb.mapped_slots[$urandom_range(0, sb.mapped_slots.size() - 1)];
      end else begin
        slot = $urandom_range(0, NUM_SLOTS - 1);
        while (sb.entry_present[slot]) slot = $urandom_range(0, NUM_SLOTS - 1);
      end
      req.directory    = 2'(slot >> 10);
      req.virtual_page = 10'(slot);
    end else begin
      req.operation = OP_FREE;
      if ($urandom_range(0, 9) != 0 && sb.mapped_slots.size() != 0) begin
        slot = sb.mapped_slots[$urandom_range(0, sb.mapped_slots.size() - 1)];
        req.directory    = 2'(slot >> 10);
        req.virtual_page = 10'(slot);
      end
    end
    return req;
  endfunction

  task automatic send_request(input in_item_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.accept_request(req);
  endtask

  // result side: random stalls, plus one long hold-off asked for by the main sequence
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_response(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // capacity at the edges of the reset pool (31 free frames)
    send_request(make_request(OP_CHECK, 2'd0, 10'd0, 32'd0));
    send_request(make_request(OP_CHECK, 2'd3, 10'h3FF, 32'hFFFF_FFFF));
    send_request(make_request(OP_CHECK, 2'd1, 10'd1, 32'h07C0_0000));
    send_request(make_request(OP_CHECK, 2'd2, 10'd2, 32'h07C0_0001));
    send_request(make_request(OP_ALLOC, 2'd0, 10'd5, 32'd0));
    send_request(make_request(OP_ALLOC, 2'd3, 10'h3FF, 32'hFFFF_FFFF));
    send_request(make_request(OP_FREE, 2'd0, 10'd5, 32'd0));
    // entry no longer present
    send_request(make_request(OP_FREE, 2'd0, 10'd5, 32'd0));
    // reserved frame 0 released through a boot mapping, then again through another
    send_request(make_request(OP_FREE, 2'd0, 10'd0, 32'd0));
    send_request(make_request(OP_FREE, 2'd1, HIGH_HALF_INDEX, 32'd0));
    send_request(make_request(OP_CHECK, 2'd0, 10'd0, 32'h0800_0000));
    send_request(make_request(OP_ALLOC, 2'd2, 10'd7, 32'd0));
    send_request(make_request(OP_UNUSED, 2'd3, 10'h3FF, 32'hFFFF_FFFF));
    // frame 0 now shared by a boot mapping and a fresh one
    send_request(make_request(OP_FREE, 2'd2, 10'd0, 32'd0));
    send_request(make_request(OP_FREE, 2'd2, 10'd7, 32'd0));
    // overwrite live mappings
    send_request(make_request(OP_ALLOC, 2'd3, 10'h3FF, 32'd0));
    send_request(make_request(OP_ALLOC, 2'd1, 10'd0, 32'd0));

    repeat (RANDOM_ITEMS / 3) send_request(random_request());
    send_idle_pct = 50;
    recv_idle_pct = 11;
    repeat (RANDOM_ITEMS / 3) send_request(random_request());
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req <= 1'b1;
    repeat (RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3)) send_request(random_request());
    in_valid <= 1'b0;

    while (sb.expected_responses.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_responses.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/pfam_pkg.sv
sv/pfam_ram.sv
sv/page_frame_allocator_mapper_top.sv
verif/testbench.sv
